@@ hdl/sphpf_pkg.sv @@
`default_nettype none
package sphpf_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PAIR = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned ACC_W = 48;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_COEFF  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FLUID_A = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FLUID_B = 4'd8;

  // One request as handed from the front end to the back end.
  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx_a;
    logic [IDX_W-1:0]   idx_b;
    logic               in_range;
    logic [30:0]        mass;
    logic [30:0]        density;
    logic signed [31:0] pressure;
    logic signed [4:0]  kind;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
  } req_t;

  // Result as handed from the back end to the output queue.
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [ACC_W-1:0] fx;
    logic signed [ACC_W-1:0] fy;
    logic signed [ACC_W-1:0] fz;
  } res_t;

endpackage
`default_nettype wire

@@ hdl/sphpf_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module sphpf_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW:0]   trial;
  logic [DW-1:0] dreg;

  assign trial = {rem[DW-1:0], quo[NW-1]} - {1'b0, dreg};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      if (!trial[DW]) begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-1:0], quo[NW-1]};
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/sphpf_fifo.sv @@
`default_nettype none
// Small register queue used between the front end and the back end.
module sphpf_fifo #(
  parameter int unsigned W = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         rd,
  output logic              empty,
  output logic [W-1:0]      rdata
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd && !empty) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end
endmodule
`default_nettype wire

@@ hdl/sphpf_engine.sv @@
`default_nettype none
// Back end: particle table, shared divider, force accumulation sequencer.
module sphpf_engine #(
  parameter int unsigned MAX_PARTICLES = 1024,
  parameter int unsigned DIMS = 3,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire sphpf_pkg::req_t req,
  output logic                 req_take,
  input  wire logic [15:0]     coeff,
  input  wire logic [3:0]      fluid_a,
  input  wire logic [3:0]      fluid_b,
  output logic                 res_valid,
  output sphpf_pkg::res_t      res,
  input  wire logic            res_full
);
  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned AW_USE = (AW < sphpf_pkg::IDX_W) ? AW : sphpf_pkg::IDX_W;
  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_I, S_RD_J, S_QDIV, S_QSQ, S_QSAT, S_TERM, S_SUM, S_REP,
    S_CHK, S_DMUL, S_DDIV, S_DSAT, S_ACC_RD, S_ACC_WR, S_READ, S_OUT
  } st_t;

  // particle table
  logic [30:0]        mass_mem [MAX_PARTICLES];
  logic [30:0]        dens_mem [MAX_PARTICLES];
  logic signed [31:0] pres_mem [MAX_PARTICLES];
  logic signed [4:0]  kind_mem [MAX_PARTICLES];
  logic signed [47:0] accx_mem [MAX_PARTICLES];
  logic signed [47:0] accy_mem [MAX_PARTICLES];
  logic signed [47:0] accz_mem [MAX_PARTICLES];

  st_t state, state_next;
  sphpf_pkg::req_t cur;

  logic [AW_USE-1:0] rd_addr, ia, ib;
  logic [30:0]        rd_mass, m_i, m_j;
  logic [30:0]        rd_dens;
  logic signed [31:0] rd_pres;
  logic signed [4:0]  rd_kind, k_i, k_j;
  logic signed [47:0] rd_ax, rd_ay, rd_az;

  // per-particle term pipeline
  logic        side;          // 0: particle i, 1: particle j
  logic [31:0] q_sat;
  logic [63:0] prod;
  logic [31:0] s_sat;
  logic [31:0] pmag;
  logic        pneg;
  logic [63:0] mag_i, mag_j;  // full term magnitude, below 2^47
  logic        neg_i, neg_j;
  logic signed [31:0] t_val;
  logic [31:0] r_val;

  // delta sequencing
  logic [1:0] lane;
  logic [1:0] phase;        // 0 press i, 1 press j, 2 rep i, 3 rep j
  logic       jf, rep;
  logic [63:0] dmag;
  logic        dneg;
  logic signed [47:0] dval;
  logic signed [47:0] acc_cur;
  logic        zero_prod;

  // divider
  logic        div_start, div_busy, div_done;
  logic [63:0] div_num, div_q;
  logic [31:0] div_den;

  sphpf_div #(.NW(64), .DW(32)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_q)
  );

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  assign ia = cur.idx_a[AW_USE-1:0];
  assign ib = cur.idx_b[AW_USE-1:0];

  logic signed [31:0] cur_g;
  always_comb begin
    case (lane)
      2'd0: cur_g = cur.gx;
      2'd1: cur_g = cur.gy;
      default: cur_g = cur.gz;
    endcase
  end

  logic cur_on_j;
  assign cur_on_j = phase[0];

  logic [AW_USE-1:0] acc_addr;
  assign acc_addr = cur_on_j ? ib : ia;

  // address held steady while a particle's ratio is being worked out
  always_comb begin
    case (state)
      S_RD_I, S_RD_J, S_QDIV: rd_addr = side ? ib : ia;
      S_READ, S_OUT:          rd_addr = ia;
      default:                rd_addr = acc_addr;
    endcase
  end

  // registered table reads
  always_ff @(posedge clk) begin
    rd_mass <= mass_mem[rd_addr];
    rd_dens <= dens_mem[rd_addr];
    rd_pres <= pres_mem[rd_addr];
    rd_kind <= kind_mem[rd_addr];
    rd_ax   <= accx_mem[rd_addr];
    rd_ay   <= accy_mem[rd_addr];
    rd_az   <= accz_mem[rd_addr];
  end

  always_comb begin
    case (lane)
      2'd0: acc_cur = rd_ax;
      2'd1: acc_cur = rd_ay;
      default: acc_cur = rd_az;
    endcase
  end

  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_new;
  assign acc_sum = {acc_cur[47], acc_cur} + {dval[47], dval};
  always_comb begin
    if (acc_sum > $signed({1'b0, ACC_MAX})) acc_new = ACC_MAX;
    else if (acc_sum < $signed({ACC_MIN[47], ACC_MIN})) acc_new = ACC_MIN;
    else acc_new = acc_sum[47:0];
  end

  // table writes: load or accumulator update
  logic ld_wr;
  assign ld_wr = (state == S_IDLE) && req_valid && (req.op == sphpf_pkg::OP_LOAD) &&
                 req.in_range;
  always_ff @(posedge clk) begin
    if (ld_wr) begin
      mass_mem[req.idx_a[AW_USE-1:0]] <= req.mass;
      dens_mem[req.idx_a[AW_USE-1:0]] <= req.density;
      pres_mem[req.idx_a[AW_USE-1:0]] <= req.pressure;
      kind_mem[req.idx_a[AW_USE-1:0]] <= req.kind;
      accx_mem[req.idx_a[AW_USE-1:0]] <= '0;
      accy_mem[req.idx_a[AW_USE-1:0]] <= '0;
      accz_mem[req.idx_a[AW_USE-1:0]] <= '0;
    end else if (state == S_ACC_WR) begin
      case (lane)
        2'd0: accx_mem[acc_addr] <= acc_new;
        2'd1: accy_mem[acc_addr] <= acc_new;
        default: accz_mem[acc_addr] <= acc_new;
      endcase
    end
  end

  logic phase_on;
  always_comb begin
    case (phase)
      2'd0: phase_on = 1'b1;
      2'd1: phase_on = jf;
      default: phase_on = rep;
    endcase
  end

  logic last_step;
  assign last_step = (phase == 2'd3) && (lane == 2'(DIMS - 1));

  always_comb begin
    state_next = state;
    req_take = 1'b0;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    case (state)
      S_IDLE: if (req_valid) begin
        req_take = 1'b1;
        case (req.op)
          sphpf_pkg::OP_PAIR: state_next = req.in_range ? S_RD_I : S_IDLE;
          sphpf_pkg::OP_READ: state_next = S_READ;
          default: state_next = S_IDLE;
        endcase
      end
      S_RD_I: state_next = S_RD_J;
      S_RD_J: state_next = S_QDIV;
      S_QDIV: begin
        if (!div_busy && !div_done) begin
          div_start = 1'b1;
          div_num = 64'({rd_mass, FRAC_BITS'(0)});
          div_den = 32'(rd_dens);
        end
        if (div_done) state_next = S_QSQ;
      end
      S_QSQ:  state_next = S_QSAT;
      S_QSAT: state_next = S_TERM;
      S_TERM: state_next = side ? S_SUM : S_RD_I;
      S_SUM:  state_next = S_REP;
      S_REP:  state_next = (k_i[4]) ? S_IDLE : S_CHK;
      S_CHK:  state_next = phase_on ? S_DMUL : (last_step ? S_IDLE : S_CHK);
      S_DMUL: state_next = S_DDIV;
      S_DDIV: begin
        if (zero_prod) state_next = S_DSAT;
        else begin
          if (!div_busy && !div_done) begin
            div_start = 1'b1;
            div_num = dmag;
            div_den = 32'(cur_on_j ? m_j : m_i);
          end
          if (div_done) state_next = S_DSAT;
        end
      end
      S_DSAT:   state_next = S_ACC_RD;
      S_ACC_RD: state_next = S_ACC_WR;
      S_ACC_WR: state_next = last_step ? S_IDLE : S_CHK;
      S_READ:   state_next = S_OUT;
      S_OUT:    if (!res_full) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath registers
  logic [63:0] q_full;
  assign q_full = div_q;
  logic [31:0] r_sum_sat;
  logic [64:0] r_sum;
  assign r_sum = {1'b0, mag_i} + {1'b0, mag_j};
  assign r_sum_sat = (r_sum > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_sum[31:0];
  logic signed [65:0] t_sum;
  assign t_sum = (neg_i ? -66'(mag_i) : 66'(mag_i)) + (neg_j ? -66'(mag_j) : 66'(mag_j));

  logic [63:0] div_cap;
  always_comb begin
    if (cur_on_j ? (m_j == '0) : (m_i == '0)) div_cap = '1;
    else div_cap = div_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result held on the table read port until the queue takes it
  assign res_valid = (state == S_OUT);
  always_comb begin
    res.idx = cur.idx_a;
    res.fx = cur.in_range ? rd_ax : '0;
    res.fy = cur.in_range ? rd_ay : '0;
    res.fz = cur.in_range ? rd_az : '0;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur <= req;
        side <= 1'b0;
      end
      S_RD_J: if (!side) begin
        m_i <= rd_mass;
        k_i <= rd_kind;
        pmag <= abs32(rd_pres);
        pneg <= rd_pres[31];
      end else begin
        m_j <= rd_mass;
        k_j <= rd_kind;
        pmag <= abs32(rd_pres);
        pneg <= rd_pres[31];
      end
      S_QDIV: if (div_done) begin
        if (rd_dens == '0 || q_full[63:32] != '0) q_sat <= '1;
        else q_sat <= q_full[31:0];
      end
      S_QSQ:  prod <= 64'(q_sat) * 64'(q_sat);
      S_QSAT: begin
        if ((prod >> FRAC_BITS) > 64'hFFFF_FFFF) s_sat <= '1;
        else s_sat <= 32'(prod >> FRAC_BITS);
      end
      S_TERM: begin
        if (!side) begin
          mag_i <= (64'(pmag) * 64'(s_sat)) >> FRAC_BITS;
          neg_i <= pneg;
        end else begin
          mag_j <= (64'(pmag) * 64'(s_sat)) >> FRAC_BITS;
          neg_j <= pneg;
        end
        side <= 1'b1;
      end
      S_SUM: begin
        if (t_sum > 66'sh7FFF_FFFF) t_val <= 32'sh7FFF_FFFF;
        else if (t_sum < -66'sh8000_0000) t_val <= 32'sh8000_0000;
        else t_val <= t_sum[31:0];
        r_val <= 32'((48'(r_sum_sat) * 48'(coeff)) >> 16);
      end
      S_REP: begin
        jf <= (k_j == {1'b0, fluid_a}) || (k_j == {1'b0, fluid_b});
        rep <= ((k_i == {1'b0, fluid_a}) && (k_j == {1'b0, fluid_b})) ||
               ((k_i == {1'b0, fluid_b}) && (k_j == {1'b0, fluid_a}));
        lane <= '0;
        phase <= '0;
      end
      S_CHK: if (!phase_on) begin
        if (phase == 2'd3) begin
          phase <= '0;
          lane <= lane + 1'b1;
        end else phase <= phase + 1'b1;
      end
      S_DMUL: begin
        if (phase[1]) begin
          dmag <= 64'(r_val) * 64'(abs32(cur_g));
          dneg <= (cur_g[31] ^ !phase[0]);
        end else begin
          dmag <= 64'(abs32(t_val)) * 64'(abs32(cur_g));
          dneg <= (t_val[31] ^ cur_g[31] ^ !phase[0]);
        end
      end
      S_DSAT: begin
        if (zero_prod) dval <= '0;
        else if (dneg) begin
          if (div_cap > 64'h8000_0000_0000) dval <= ACC_MIN;
          else dval <= 48'(-div_cap);
        end else begin
          if (div_cap > 64'h7FFF_FFFF_FFFF) dval <= ACC_MAX;
          else dval <= div_cap[47:0];
        end
      end
      S_ACC_WR: begin
        if (phase == 2'd3) begin
          phase <= '0;
          lane <= lane + 1'b1;
        end else phase <= phase + 1'b1;
      end
      default: ;
    endcase
  end

  assign zero_prod = (dmag == '0);
endmodule
`default_nettype wire

@@ hdl/sphpf_front.sv @@
`default_nettype none
// Front end: takes requests, checks index range, queues them.
module sphpf_front #(
  parameter int unsigned MAX_PARTICLES = 1024,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire sphpf_pkg::req_t in_req,
  output logic                 q_valid,
  output sphpf_pkg::req_t      q_req,
  input  wire logic            q_take
);
  sphpf_pkg::req_t cls;
  logic q_empty;

  always_comb begin
    cls = in_req;
    case (in_req.op)
      sphpf_pkg::OP_PAIR:
        cls.in_range = (32'(in_req.idx_a) < MAX_PARTICLES) &&
                       (32'(in_req.idx_b) < MAX_PARTICLES);
      default: cls.in_range = (32'(in_req.idx_a) < MAX_PARTICLES);
    endcase
  end

  sphpf_fifo #(.W($bits(sphpf_pkg::req_t)), .DEPTH(DEPTH)) u_q (
    .clk(clk), .rst(rst), .wr(push), .wdata(cls), .full(full),
    .rd(q_take), .empty(q_empty), .rdata(q_req)
  );
  assign q_valid = !q_empty;
endmodule
`default_nettype wire

@@ hdl/sph_pair_pressure_force_accumulator.sv @@
`default_nettype none
// Channel   Handshake          Payload
// request   push / full        operation, index_a/b, particle_*, grad_x/y/z
// result    empty / pop        read_index, force_x/y/z
// config    APB psel/penable   repulsion_coeff @0, fluid_type_a @4, fluid_type_b @8
//
// Pair: two ratio divisions plus one division per applied force delta with a
// nonzero product (up to 12), all on the single shared restoring divider.
// Reset (rst, synchronous) clears control only; table contents are undefined
// until loaded. A two-entry request queue and a two-entry result queue let
// each side stall independently.
module sph_pair_pressure_force_accumulator #(
  parameter int unsigned MAX_PARTICLES = 1024,
  parameter int unsigned DIMS = 3,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [1:0]   operation,
  input  wire logic [9:0]   index_a,
  input  wire logic [9:0]   index_b,
  input  wire logic [30:0]  particle_mass,
  input  wire logic [30:0]  particle_density,
  input  wire logic signed [31:0] particle_pressure,
  input  wire logic signed [4:0]  particle_kind,
  input  wire logic signed [31:0] grad_x,
  input  wire logic signed [31:0] grad_y,
  input  wire logic signed [31:0] grad_z,
  output logic              empty,
  input  wire logic         pop,
  output logic [9:0]        read_index,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [15:0] coeff;
  logic [3:0]  fluid_a, fluid_b;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= 16'd4588;
      fluid_a <= 4'd1;
      fluid_b <= 4'd8;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        sphpf_pkg::REG_COEFF:   coeff <= pwdata[15:0];
        sphpf_pkg::REG_FLUID_A: fluid_a <= pwdata[3:0];
        sphpf_pkg::REG_FLUID_B: fluid_b <= pwdata[3:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      sphpf_pkg::REG_COEFF:   prdata = {16'd0, coeff};
      sphpf_pkg::REG_FLUID_A: prdata = {28'd0, fluid_a};
      sphpf_pkg::REG_FLUID_B: prdata = {28'd0, fluid_b};
      default: prdata = '0;
    endcase
  end

  sphpf_pkg::req_t in_req, q_req;
  logic q_valid, q_take;
  always_comb begin
    in_req.op = sphpf_pkg::op_t'(operation);
    in_req.idx_a = index_a;
    in_req.idx_b = index_b;
    in_req.in_range = 1'b0;
    in_req.mass = particle_mass;
    in_req.density = particle_density;
    in_req.pressure = particle_pressure;
    in_req.kind = particle_kind;
    in_req.gx = grad_x;
    in_req.gy = grad_y;
    in_req.gz = grad_z;
  end

  sphpf_front #(.MAX_PARTICLES(MAX_PARTICLES), .DEPTH(2)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_req(in_req),
    .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
  );

  logic res_valid, res_full;
  sphpf_pkg::res_t res, res_q;

  sphpf_engine #(.MAX_PARTICLES(MAX_PARTICLES), .DIMS(DIMS), .FRAC_BITS(FRAC_BITS)) u_eng (
    .clk(clk), .rst(rst), .req_valid(q_valid), .req(q_req), .req_take(q_take),
    .coeff(coeff), .fluid_a(fluid_a), .fluid_b(fluid_b),
    .res_valid(res_valid), .res(res), .res_full(res_full)
  );

  // result queue
  sphpf_fifo #(.W($bits(sphpf_pkg::res_t)), .DEPTH(2)) u_rq (
    .clk(clk), .rst(rst), .wr(res_valid), .wdata(res), .full(res_full),
    .rd(pop), .empty(empty), .rdata(res_q)
  );
  assign read_index = res_q.idx;
  assign force_x = res_q.fx;
  assign force_y = res_q.fy;
  assign force_z = res_q.fz;
endmodule
`default_nettype wire
